// ----- rtl/odo_pkg.sv -----
`default_nettype none
package odo_pkg;

    // Fixed-point constants: Q24 angles, Q16 heading period, microsecond scale.
    localparam int ANG_W = 30;
    localparam int CRD_W = 28;
    localparam int CORDIC_STEPS = 24;
    localparam int DVD_W = 64;
    localparam int DEN_W = 21;
    localparam int DIV_CNT_W = 6;

    // Constant divider: radix-2048 digits, each found by a reciprocal estimate.
    localparam int CDIV_DIG_W  = 11;
    localparam int CDIV_DIGITS = 6;
    localparam int CDIV_NUM_W  = CDIV_DIG_W * CDIV_DIGITS;
    localparam int CDIV_CNT_W  = 3;
    localparam int RCP_W       = 14;

    localparam logic signed [ANG_W-1:0] Q24_PI      = 30'sd52707179;
    localparam logic signed [ANG_W-1:0] Q24_TWO_PI  = 30'sd105414357;
    localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 30'sd26353589;
    localparam logic signed [CRD_W-1:0] Q24_GAIN    = 28'sd10188014;
    localparam logic [DEN_W-1:0] Q16_TWO_PI   = 21'd411775;
    localparam logic [DEN_W-1:0] US_TIMES_TWO = 21'd2000000;

    // Reciprocals floor(2^32 / divisor) of the two constant divisors.
    localparam logic [RCP_W-1:0] RCP_TIME = 14'd2147;
    localparam logic [RCP_W-1:0] RCP_HEAD = 14'd10430;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RADIUS     = 3'd0;
    localparam logic [2:0] REG_SPACING    = 3'd1;
    localparam logic [2:0] REG_START_X    = 3'd2;
    localparam logic [2:0] REG_START_Y    = 3'd3;
    localparam logic [2:0] REG_START_HEAD = 3'd4;
    localparam logic [2:0] REG_START_TIME = 3'd5;

    // Reset values of the registers.
    localparam logic [15:0] RST_RADIUS    = 16'd3277;
    localparam logic [19:0] RST_SPACING   = 20'd32768;
    localparam logic [18:0] RST_START_HD  = 19'd102957;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_CORD = 14'b00000000000010,
        ST_MRS  = 14'b00000000000100,
        ST_MTN  = 14'b00000000001000,
        ST_MVX  = 14'b00000000010000,
        ST_MVY  = 14'b00000000100000,
        ST_DTN  = 14'b00000001000000,
        ST_WTN  = 14'b00000010000000,
        ST_AMUL = 14'b00000100000000,
        ST_ADIV = 14'b00001000000000,
        ST_AWT  = 14'b00010000000000,
        ST_MOD  = 14'b00100000000000,
        ST_MWT  = 14'b01000000000000,
        ST_DONE = 14'b10000000000000
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_RS   = 3'd1,
        MUL_TN   = 3'd2,
        MUL_VX   = 3'd3,
        MUL_VY   = 3'd4,
        MUL_AREA = 3'd5
    } t_mul_op;

    typedef enum logic [1:0] {
        DIV_TURN = 2'd0,
        DIV_AREA = 2'd1,
        DIV_MOD  = 2'd2
    } t_div_src;

    localparam logic [1:0] AREA_X = 2'd0;
    localparam logic [1:0] AREA_Y = 2'd1;
    localparam logic [1:0] AREA_H = 2'd2;

    typedef struct packed {
        logic     load;
        logic     cord;
        logic [4:0] iter;
        t_mul_op  mul_op;
        logic     cap_rs;
        logic     cap_num;
        logic     cap_vx;
        logic     cap_vy;
        logic     div_start;
        t_div_src div_src;
        logic     cap_turn;
        logic     cap_area;
        logic [1:0] area_k;
        logic     cap_mod;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cdiv_done;
        logic out_full;
    } t_stat;

    // Elementary rotation angle of one CORDIC step, Q24.
    function automatic logic [23:0] step_angle(input logic [4:0] i);
        logic [24:0] pw;
        pw = 25'd1 << (5'd24 - i);
        case (i)
            5'd0: step_angle = 24'd13176795;
            5'd1: step_angle = 24'd7778716;
            5'd2: step_angle = 24'd4110060;
            5'd3: step_angle = 24'd2086331;
            5'd4: step_angle = 24'd1047214;
            5'd5: step_angle = 24'd524117;
            5'd6: step_angle = 24'd262123;
            5'd7: step_angle = 24'd131069;
            default: step_angle = pw[23:0];
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/odo_div.sv -----
`default_nettype none
module odo_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [odo_pkg::DVD_W-1:0]   i_dividend,
    input  wire [odo_pkg::DEN_W-1:0]   i_divisor,
    output logic [odo_pkg::DVD_W-1:0]  o_quot,
    output logic                       o_done
);
    import odo_pkg::*;

    logic [DVD_W-1:0]     r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        rem_sh  = {r_rem, r_q[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// Division by one of two constants, one radix-2048 digit at a time. For each digit, the
// first phase estimates it from a reciprocal, the second forms the partial
// remainder and corrects the estimate, which is never more than one too small.
module odo_cdiv (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire                        i_sel_head,
    input  wire [odo_pkg::DVD_W-1:0]   i_dividend,
    output logic [odo_pkg::DVD_W-1:0]  o_quot,
    output logic [odo_pkg::DEN_W-1:0]  o_rem,
    output logic                       o_done
);
    import odo_pkg::*;

    logic [CDIV_NUM_W-1:0] r_num;
    logic [CDIV_NUM_W-1:0] r_q;
    logic [DEN_W-1:0]      r_rem;
    logic [DEN_W-1:0]      r_den;
    logic [RCP_W-1:0]      r_rcp;
    logic [CDIV_DIG_W-1:0] r_qe;
    logic [CDIV_CNT_W-1:0] r_cnt;
    logic                  r_phase;
    logic                  r_busy;
    logic                  r_done;

    logic [31:0]           part;
    logic [45:0]           est_p;
    logic [31:0]           qd;
    logic [31:0]           try_rem;
    logic                  corr;
    logic [DEN_W-1:0]      n_rem;
    logic [CDIV_DIG_W-1:0] digit;

    // Partial remainder with the next digit of the dividend, estimate and correction.
    always_comb begin
        part    = {r_rem, r_num[CDIV_NUM_W-1 -: CDIV_DIG_W]};
        est_p   = 46'(part) * 46'(r_rcp);
        qd      = 32'(r_qe) * 32'(r_den);
        try_rem = part - qd;
        corr    = (try_rem >= 32'(r_den));
        n_rem   = corr ? DEN_W'(try_rem - 32'(r_den)) : DEN_W'(try_rem);
        digit   = r_qe + CDIV_DIG_W'(corr);
    end

    // Control of the digit sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CDIV_CNT_W'(CDIV_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend, quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= CDIV_NUM_W'(i_dividend);
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_sel_head ? Q16_TWO_PI : US_TIMES_TWO;
            r_rcp <= i_sel_head ? RCP_HEAD : RCP_TIME;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_qe <= est_p[32 +: CDIV_DIG_W];
            end else begin
                r_q   <= {r_q[CDIV_NUM_W-CDIV_DIG_W-1:0], digit};
                r_num <= {r_num[CDIV_NUM_W-CDIV_DIG_W-1:0], {CDIV_DIG_W{1'b0}}};
                r_rem <= n_rem;
            end
        end
    end

    assign o_quot = r_q[DVD_W-1:0];
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- rtl/odo_ctrl.sv -----
`default_nettype none
module odo_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  odo_pkg::t_stat i_stat,
    output odo_pkg::t_cmd  o_cmd
);
    import odo_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;

    // Sequencer: CORDIC, four products, turn divide, three areas, heading wrap.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.iter   = r_cnt;
        o_cmd.area_k = r_k;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.div_src = DIV_TURN;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_CORD;
                end
            end
            ST_CORD: begin
                o_cmd.cord = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = ST_MRS;
                end
            end
            ST_MRS: begin
                o_cmd.mul_op = MUL_RS;
                n_state = ST_MTN;
            end
            ST_MTN: begin
                o_cmd.cap_rs = 1'b1;
                o_cmd.mul_op = MUL_TN;
                n_state = ST_MVX;
            end
            ST_MVX: begin
                o_cmd.cap_num = 1'b1;
                o_cmd.mul_op  = MUL_VX;
                n_state = ST_MVY;
            end
            ST_MVY: begin
                o_cmd.cap_vx = 1'b1;
                o_cmd.mul_op = MUL_VY;
                n_state = ST_DTN;
            end
            ST_DTN: begin
                o_cmd.cap_vy    = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_TURN;
                n_state = ST_WTN;
            end
            ST_WTN: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_turn = 1'b1;
                    n_k     = AREA_X;
                    n_state = ST_AMUL;
                end
            end
            ST_AMUL: begin
                o_cmd.mul_op = MUL_AREA;
                n_state = ST_ADIV;
            end
            ST_ADIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_AREA;
                n_state = ST_AWT;
            end
            ST_AWT: begin
                if (i_stat.cdiv_done) begin
                    o_cmd.cap_area = 1'b1;
                    if (r_k == AREA_H) begin
                        n_state = ST_MOD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_AMUL;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_MOD;
                n_state = ST_MWT;
            end
            ST_MWT: begin
                if (i_stat.cdiv_done) begin
                    o_cmd.cap_mod = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/odo_dp.sv -----
`default_nettype none
module odo_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  odo_pkg::t_cmd       i_cmd,
    output odo_pkg::t_stat      o_stat,
    input  wire signed [15:0]   i_left_rate,
    input  wire signed [15:0]   i_right_rate,
    input  wire [31:0]          i_stamp,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [19:0]  o_heading,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_idx,
    input  wire [31:0]          i_cfg_data,
    output logic [31:0]         o_cfg_rdata
);
    import odo_pkg::*;

    // Configuration registers.
    logic [15:0] r_radius;
    logic [19:0] r_spacing;
    logic [31:0] r_start_x, r_start_y, r_start_time;
    logic [18:0] r_start_hd;

    // Pose and velocity state.
    logic [31:0]        r_cur_x, r_cur_y, r_last_stamp;
    logic signed [19:0] r_cur_hd;
    logic signed [31:0] r_prev_vx, r_prev_vy, r_prev_turn;

    // Working registers of one request.
    logic signed [16:0]      r_sum, r_diff;
    logic [31:0]             r_dt, r_stamp;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic signed [ANG_W-1:0] r_ca;
    logic                    r_flip;
    logic signed [67:0]      r_prod;
    logic signed [33:0]      r_rs;
    logic signed [40:0]      r_num;
    logic signed [31:0]      r_vx, r_vy, r_turn;
    logic                    r_asign;
    logic signed [45:0]      r_hsum;
    logic                    r_out_valid;

    // Heading into [-pi, pi] and then [-pi/2, pi/2].
    logic signed [ANG_W-1:0] a0, a1, a2;
    logic                    flip0;
    always_comb begin
        a0 = {{(ANG_W-28){r_cur_hd[19]}}, r_cur_hd, 8'b0};
        if (a0 > Q24_PI) begin
            a1 = a0 - Q24_TWO_PI;
        end else if (a0 < -Q24_PI) begin
            a1 = a0 + Q24_TWO_PI;
        end else begin
            a1 = a0;
        end
        flip0 = 1'b1;
        if (a1 > Q24_HALF_PI) begin
            a2 = a1 - Q24_PI;
        end else if (a1 < -Q24_HALF_PI) begin
            a2 = a1 + Q24_PI;
        end else begin
            a2 = a1;
            flip0 = 1'b0;
        end
    end

    // One CORDIC rotation.
    logic signed [CRD_W-1:0] sh_x, sh_y, nx, ny;
    logic signed [ANG_W-1:0] ang, na;
    always_comb begin
        sh_x = r_cx >>> i_cmd.iter;
        sh_y = r_cy >>> i_cmd.iter;
        ang  = $signed({{(ANG_W-24){1'b0}}, step_angle(i_cmd.iter)});
        if (!r_ca[ANG_W-1]) begin
            nx = r_cx - sh_y;
            ny = r_cy + sh_x;
            na = r_ca - ang;
        end else begin
            nx = r_cx + sh_y;
            ny = r_cy - sh_x;
            na = r_ca + ang;
        end
    end

    // Signed cosine and sine after the fold.
    logic signed [CRD_W-1:0] cosv, sinv;
    assign cosv = r_flip ? -r_cx : r_cx;
    assign sinv = r_flip ? -r_cy : r_cy;

    // Area operand: sum of previous and new rate for the selected term.
    logic signed [31:0] ar_prev, ar_new;
    logic signed [32:0] asum;
    logic [32:0]        amag;
    always_comb begin
        case (i_cmd.area_k)
            AREA_X: begin
                ar_prev = r_prev_vx;
                ar_new  = r_vx;
            end
            AREA_Y: begin
                ar_prev = r_prev_vy;
                ar_new  = r_vy;
            end
            default: begin
                ar_prev = r_prev_turn;
                ar_new  = r_turn;
            end
        endcase
        asum = 33'(ar_prev) + 33'(ar_new);
        amag = asum[32] ? 33'(-asum) : 33'(asum);
    end

    // Shared multiplier with a registered product.
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    always_comb begin
        case (i_cmd.mul_op)
            MUL_RS: begin
                ma = $signed({18'b0, r_radius});
                mb = 34'(r_sum);
            end
            MUL_TN: begin
                ma = $signed({18'b0, r_radius});
                mb = 34'(r_diff);
            end
            MUL_VX: begin
                ma = r_rs;
                mb = 34'(cosv);
            end
            MUL_VY: begin
                ma = r_rs;
                mb = 34'(sinv);
            end
            MUL_AREA: begin
                ma = $signed({1'b0, amag});
                mb = $signed({2'b0, r_dt});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        mp = ma * mb;
    end

    // Rounded Q16.16 velocity from a Q24 product.
    logic signed [67:0] vround;
    assign vround = r_prod + (68'sd1 <<< 32);

    // Divider operands: the turn rate goes to the general divider, the areas
    // and the heading wrap to the constant divider.
    logic [DEN_W-1:0] dv_den;
    logic             dv_start;
    logic [DVD_W-1:0] dv_quot;
    logic             dv_done;
    logic             cd_start;
    logic             cd_head;
    logic [DVD_W-1:0] cd_dvd;
    logic [DVD_W-1:0] cd_quot;
    logic [DEN_W-1:0] cd_rem;
    logic             cd_done;
    logic [40:0]      num_mag;
    logic [45:0]      hs_mag;
    always_comb begin
        num_mag  = r_num[40] ? 41'(-r_num) : 41'(r_num);
        hs_mag   = r_hsum[45] ? 46'(-r_hsum) : 46'(r_hsum);
        dv_den   = (r_spacing == '0) ? DEN_W'(1) : DEN_W'(r_spacing);
        dv_start = i_cmd.div_start && (i_cmd.div_src == DIV_TURN);
        cd_start = i_cmd.div_start && (i_cmd.div_src != DIV_TURN);
        cd_head  = (i_cmd.div_src == DIV_MOD);
        cd_dvd   = cd_head ? DVD_W'(hs_mag) : r_prod[DVD_W-1:0];
    end

    odo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (DVD_W'(num_mag)),
        .i_divisor  (dv_den),
        .o_quot     (dv_quot),
        .o_done     (dv_done)
    );

    odo_cdiv u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cd_start),
        .i_sel_head (cd_head),
        .i_dividend (cd_dvd),
        .o_quot     (cd_quot),
        .o_rem      (cd_rem),
        .o_done     (cd_done)
    );

    // Signed and saturated turn rate, signed area delta, signed remainder.
    logic signed [31:0]      turn_sat;
    logic signed [DVD_W-1:0] delta;
    logic signed [19:0]      hd_wrap;
    always_comb begin
        if (r_num[40]) begin
            turn_sat = (dv_quot > DVD_W'(64'h8000_0000)) ? 32'sh8000_0000
                                                         : -$signed(dv_quot[31:0]);
        end else begin
            turn_sat = (dv_quot > DVD_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : $signed(dv_quot[31:0]);
        end
        delta   = r_asign ? -$signed(cd_quot) : $signed(cd_quot);
        hd_wrap = r_hsum[45] ? -$signed(cd_rem[19:0]) : $signed(cd_rem[19:0]);
    end

    // Configuration registers and the pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RST_RADIUS;
            r_spacing    <= RST_SPACING;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_start_hd   <= RST_START_HD;
            r_start_time <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_hd     <= 20'(signed'(RST_START_HD));
            r_last_stamp <= '0;
            r_prev_vx    <= '0;
            r_prev_vy    <= '0;
            r_prev_turn  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                REG_SPACING: r_spacing <= i_cfg_data[19:0];
                REG_START_X: begin
                    r_start_x <= i_cfg_data;
                    r_cur_x   <= i_cfg_data;
                end
                REG_START_Y: begin
                    r_start_y <= i_cfg_data;
                    r_cur_y   <= i_cfg_data;
                end
                REG_START_HEAD: begin
                    r_start_hd <= i_cfg_data[18:0];
                    r_cur_hd   <= {i_cfg_data[18], i_cfg_data[18:0]};
                end
                REG_START_TIME: begin
                    r_start_time <= i_cfg_data;
                    r_last_stamp <= i_cfg_data;
                end
                default: ;
            endcase
        end else begin
            if (i_cmd.cap_area) begin
                case (i_cmd.area_k)
                    AREA_X:  r_cur_x <= r_cur_x + delta[31:0];
                    AREA_Y:  r_cur_y <= r_cur_y + delta[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.cap_mod) begin
                r_cur_hd <= hd_wrap;
            end
            if (i_cmd.commit) begin
                r_prev_vx    <= r_vx;
                r_prev_vy    <= r_vy;
                r_prev_turn  <= r_turn;
                r_last_stamp <= r_stamp;
            end
        end
    end

    // Register readback.
    always_comb begin
        unique case (i_cfg_idx)
            REG_RADIUS:     o_cfg_rdata = {16'b0, r_radius};
            REG_SPACING:    o_cfg_rdata = {12'b0, r_spacing};
            REG_START_X:    o_cfg_rdata = r_start_x;
            REG_START_Y:    o_cfg_rdata = r_start_y;
            REG_START_HEAD: o_cfg_rdata = {{13{r_start_hd[18]}}, r_start_hd};
            REG_START_TIME: o_cfg_rdata = r_start_time;
            default:        o_cfg_rdata = '0;
        endcase
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum   <= 17'(i_left_rate) + 17'(i_right_rate);
            r_diff  <= 17'(i_right_rate) - 17'(i_left_rate);
            r_dt    <= i_stamp - r_last_stamp;
            r_stamp <= i_stamp;
            r_cx    <= Q24_GAIN;
            r_cy    <= '0;
            r_ca    <= a2;
            r_flip  <= flip0;
        end
        if (i_cmd.cord) begin
            r_cx <= nx;
            r_cy <= ny;
            r_ca <= na;
        end
        r_prod <= mp;
        if (i_cmd.mul_op == MUL_AREA) begin
            r_asign <= asum[32];
        end
        if (i_cmd.cap_rs) begin
            r_rs <= r_prod[33:0];
        end
        if (i_cmd.cap_num) begin
            r_num <= {r_prod[33:0], 7'b0};
        end
        if (i_cmd.cap_vx) begin
            r_vx <= vround[64:33];
        end
        if (i_cmd.cap_vy) begin
            r_vy <= vround[64:33];
        end
        if (i_cmd.cap_turn) begin
            r_turn <= turn_sat;
        end
        if (i_cmd.cap_area && (i_cmd.area_k == AREA_H)) begin
            r_hsum <= 46'(r_cur_hd) + delta[45:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_pos_x   <= r_cur_x;
            o_pos_y   <= r_cur_y;
            o_heading <= r_cur_hd;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.div_done  = dv_done;
    assign o_stat.cdiv_done = cd_done;
    assign o_stat.out_full  = r_out_valid && !i_out_ready;

endmodule
`default_nettype wire

// ----- rtl/differential_drive_odometry_core.sv -----
`default_nettype none
// Trapezoidal dead-reckoning odometry for a two-wheel robot. Each request carries the
// left and right wheel rates and a timestamp and yields one pose (x, y, heading). A
// request goes through 24 CORDIC steps, four products on the shared multiplier, a
// 64-step turn-rate division on the one-bit-per-cycle divider, which takes the
// largest share of the work, and four divisions by constants (three trapezoid areas
// and the heading wrap), each of six radix-2048 digits. A new request is taken once
// the previous result has moved into the output register. Writing start_x, start_y,
// start_heading or start_time also loads the matching pose or time state; configure
// only while the block is idle.
module differential_drive_odometry_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire signed [15:0]  i_left_rate,
    input  wire signed [15:0]  i_right_rate,
    input  wire [31:0]         i_stamp,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [19:0] o_heading,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [4:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import odo_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    odo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    odo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_left_rate  (i_left_rate),
        .i_right_rate (i_right_rate),
        .i_stamp      (i_stamp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_heading    (o_heading),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (paddr[4:2]),
        .i_cfg_data   (pwdata),
        .o_cfg_rdata  (prdata)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted request");

    // A new result only appears at the end of work on a request.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised while the block was idle");

    // The reported heading stays within one period.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading <= 20'sd411774 && o_heading >= -20'sd411774))
        else $error("heading outside one period");
`endif

endmodule
`default_nettype wire

// ----- tb/odometry_scoreboard.sv -----
`default_nettype none
// Watches the request, result and register channels of the odometry core, keeps its own
// copy of the pose state and checks every result against the predicted pose.
module odometry_scoreboard (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire signed [15:0] i_left_rate,
    input  wire signed [15:0] i_right_rate,
    input  wire [31:0]        i_stamp,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire signed [31:0] i_pos_x,
    input  wire signed [31:0] i_pos_y,
    input  wire signed [19:0] i_heading,
    input  wire               i_psel,
    input  wire               i_penable,
    input  wire               i_pwrite,
    input  wire [4:0]         i_paddr,
    input  wire [31:0]        i_pwdata,
    input  wire               i_pready,
    output int                o_errors,
    output int                o_pending,
    output int                o_poses_checked
);
    import odo_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [19:0] hd;
    } t_pose;

    // Fixed-point scaling of the shared arithmetic.
    localparam longint Q24_PI_L      = 52707179;
    localparam longint Q24_TWO_PI_L  = 105414357;
    localparam longint Q24_HALF_PI_L = 26353589;
    localparam longint GAIN_L        = 10188014;
    localparam longint HEAD_PERIOD   = 411775;

    // Register copies and pose state.
    logic [15:0] radius;
    logic [19:0] spacing;
    logic [31:0] pose_x, pose_y, prev_stamp;
    longint      pose_hd, vx_prev, vy_prev, turn_prev;

    t_pose pose_q[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotation-mode CORDIC for cosine and sine of a Q16 heading, results in Q24.
    function automatic void heading_trig(input longint hq, output longint c,
                                         output longint s);
        longint a, x, y, nx, stp;
        bit flip;
        a = hq * 256;
        x = GAIN_L;
        y = 0;
        flip = 0;
        while (a > Q24_PI_L) a -= Q24_TWO_PI_L;
        while (a < -Q24_PI_L) a += Q24_TWO_PI_L;
        if (a > Q24_HALF_PI_L) begin
            a -= Q24_PI_L;
            flip = 1;
        end else if (a < -Q24_HALF_PI_L) begin
            a += Q24_PI_L;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            stp = longint'(step_angle(5'(i)));
            if (a >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a -= stp;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a += stp;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Trapezoid area in the pose unit; magnitude product wraps at 64 bits.
    function automatic longint trapezoid(input longint a, input longint b,
                                         input logic [31:0] dt);
        longint sum;
        logic [63:0] mag, q;
        sum = a + b;
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        q = (mag * {32'd0, dt}) / 64'd2000000;
        return (sum < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Advances the pose by one wheel-rate request and returns it.
    function automatic t_pose pose_step(input logic signed [15:0] lr,
                                        input logic signed [15:0] rr,
                                        input logic [31:0] st);
        longint rs, c, s, vx, vy, tn, den, h;
        logic [31:0] dt;
        t_pose p;
        dt = st - prev_stamp;
        den = (spacing == 0) ? 1 : longint'(spacing);
        rs = longint'(radius) * (longint'(lr) + longint'(rr));
        heading_trig(pose_hd, c, s);
        vx = clamp32((rs * c + (64'sd1 <<< 32)) >>> 33);
        vy = clamp32((rs * s + (64'sd1 <<< 32)) >>> 33);
        tn = clamp32((longint'(radius) * (longint'(rr) - longint'(lr)) * 128) / den);
        pose_x = pose_x + 32'(trapezoid(vx_prev, vx, dt));
        pose_y = pose_y + 32'(trapezoid(vy_prev, vy, dt));
        h = pose_hd + trapezoid(turn_prev, tn, dt);
        pose_hd = h % HEAD_PERIOD;
        vx_prev = vx;
        vy_prev = vy;
        turn_prev = tn;
        prev_stamp = st;
        p.x = pose_x;
        p.y = pose_y;
        p.hd = 20'(pose_hd);
        return p;
    endfunction

    assign o_pending = pose_q.size();

    always @(posedge i_clk) begin
        t_pose want;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            radius = RST_RADIUS;
            spacing = RST_SPACING;
            pose_x = '0;
            pose_y = '0;
            pose_hd = 102957;
            vx_prev = 0;
            vy_prev = 0;
            turn_prev = 0;
            prev_stamp = '0;
            pose_q.delete();
            o_errors <= 0;
            o_poses_checked <= 0;
        end else begin
            // Register writes; a start value also reloads its state.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_RADIUS:     radius = i_pwdata[15:0];
                    REG_SPACING:    spacing = i_pwdata[19:0];
                    REG_START_X:    pose_x = i_pwdata;
                    REG_START_Y:    pose_y = i_pwdata;
                    REG_START_HEAD: pose_hd = longint'($signed(i_pwdata[18:0]));
                    REG_START_TIME: prev_stamp = i_pwdata;
                    default: ;
                endcase
            end
            // Accepted request: predict its pose.
            if (i_in_valid && i_in_ready)
                pose_q.push_back(pose_step(i_left_rate, i_right_rate, i_stamp));
            // Accepted result: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                o_poses_checked <= o_poses_checked + 1;
                if (pose_q.size() == 0) begin
                    $error("pose result with no request outstanding");
                    errs++;
                end else begin
                    want = pose_q.pop_front();
                    if (i_pos_x !== want.x) begin
                        $error("pos_x expected %0d actual %0d", $signed(want.x), i_pos_x);
                        errs++;
                    end
                    if (i_pos_y !== want.y) begin
                        $error("pos_y expected %0d actual %0d", $signed(want.y), i_pos_y);
                        errs++;
                    end
                    if (i_heading !== want.hd) begin
                        $error("heading expected %0d actual %0d", $signed(want.hd),
                               i_heading);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule
`default_nettype wire

// ----- tb/differential_drive_odometry_core_tb.sv -----
`default_nettype none
module differential_drive_odometry_core_tb;
    import odo_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 800;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic signed [15:0] i_left_rate = '0;
    logic signed [15:0] i_right_rate = '0;
    logic [31:0]        i_stamp = '0;
    logic               i_out_ready = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    wire                o_in_ready, o_out_valid, pready;
    wire signed [31:0]  o_pos_x, o_pos_y;
    wire signed [19:0]  o_heading;
    wire [31:0]         prdata;

    int errors, pending, poses_checked;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 0;
    int requests_sent = 0;
    int cycle_count = 0;
    logic [31:0] stamp_now = '0;

    differential_drive_odometry_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_left_rate(i_left_rate), .i_right_rate(i_right_rate), .i_stamp(i_stamp),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_heading(o_heading),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    odometry_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_left_rate(i_left_rate), .i_right_rate(i_right_rate), .i_stamp(i_stamp),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_heading(o_heading),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending), .o_poses_checked(poses_checked)
    );

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("differential_drive_odometry_core_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // One register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sends one wheel-rate request, with random idle cycles ahead of it.
    task automatic send_rates(input logic [15:0] lr, input logic [15:0] rr,
                              input logic [31:0] st);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_rate <= lr;
        i_right_rate <= rr;
        i_stamp <= st;
        #1;
        while (!o_in_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every predicted pose has come back, plus a settling margin.
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random wheel rates: mostly moderate, sometimes the full range.
    task automatic random_rates(input int count);
        logic [15:0] lr, rr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                lr = 16'($urandom);
                rr = 16'($urandom);
            end else begin
                lr = 16'($signed(12'($urandom)));
                rr = 16'($signed(lr) + $signed(9'($urandom)));
            end
            // Time mostly advances in realistic steps, sometimes jumps anywhere.
            if ($urandom_range(9) == 0)
                stamp_now = $urandom;
            else
                stamp_now = stamp_now + $urandom_range(20000, 1);
            send_rates(lr, rr, stamp_now);
        end
        end_burst();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, rate extremes, time going backwards.
        send_rates(16'h0000, 16'h0000, 32'd1000);
        send_rates(16'h7FFF, 16'h7FFF, 32'd2000);
        send_rates(16'h8000, 16'h8000, 32'd3000);
        send_rates(16'h8000, 16'h7FFF, 32'd4000);
        send_rates(16'h7FFF, 16'h8000, 32'd5000);
        send_rates(16'h0100, 16'h0200, 32'd100);
        send_rates(16'h0100, 16'h0100, 32'hFFFF_FFFF);
        send_rates(16'hFF00, 16'h0300, 32'd0);
        end_burst();
        wait_idle();

        // Huge turn rate with zero spacing, wide values, unused register index.
        reg_write(REG_RADIUS, 32'hABCD_FFFF);
        reg_write(REG_SPACING, 32'hFFF0_0000);
        reg_write(REG_START_X, 32'h7FFF_FFFF);
        reg_write(REG_START_Y, 32'h8000_0000);
        reg_write(REG_START_HEAD, 32'hFFFC_DBC1);
        reg_write(REG_START_TIME, 32'hFFFF_FF00);
        reg_write(REG_UNUSED, 32'h1234_5678);
        send_rates(16'h8000, 16'h7FFF, 32'h0000_1000);
        send_rates(16'h7FFF, 16'h8000, 32'h0100_0000);
        send_rates(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        send_rates(16'h0001, 16'hFFFF, 32'h8000_0000);
        end_burst();
        wait_idle();

        // Opposite heading extreme, widest spacing, smallest radius.
        reg_write(REG_RADIUS, 32'd1);
        reg_write(REG_SPACING, 32'h000F_FFFF);
        reg_write(REG_START_HEAD, 32'd205887);
        reg_write(REG_START_TIME, 32'd0);
        send_rates(16'h7FFF, 16'h8000, 32'd50000);
        send_rates(16'h1234, 16'h4321, 32'd90000);
        end_burst();
        wait_idle();

        // Random phase one: sender idles less than the receiver, with a long hold-off.
        reg_write(REG_RADIUS, 32'd3277);
        reg_write(REG_SPACING, 32'd32768);
        reg_write(REG_START_X, 32'd0);
        reg_write(REG_START_Y, 32'd0);
        reg_write(REG_START_HEAD, 32'd0);
        reg_write(REG_START_TIME, stamp_now);
        send_idle_pct = 31;
        recv_stall_pct = 68;
        fork
            begin
                @(negedge i_clk);
                recv_hold = 1;
                repeat (3000) @(negedge i_clk);
                recv_hold = 0;
            end
            random_rates(500);
        join
        wait_idle();

        // Random phase two: the other way round, large wheels, close spacing.
        reg_write(REG_RADIUS, 32'd65535);
        reg_write(REG_SPACING, 32'd1);
        reg_write(REG_START_HEAD, 32'h0004_0000);
        send_idle_pct = 68;
        recv_stall_pct = 31;
        random_rates(500);
        wait_idle();

        // Random phase three: no idling at all.
        reg_write(REG_RADIUS, 32'd20000);
        reg_write(REG_SPACING, 32'd200000);
        reg_write(REG_START_X, $urandom);
        reg_write(REG_START_Y, $urandom);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_rates(500);
        wait_idle();

        $display("Covered %0d wheel-rate requests and %0d checked poses over", requests_sent,
                 poses_checked);
        $display("several register settings, three idling modes and a long output hold-off.");
        if (errors == 0)
            $display("differential_drive_odometry_core_tb: clean");
        else
            $display("differential_drive_odometry_core_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/odo_pkg.sv
rtl/odo_div.sv
rtl/odo_ctrl.sv
rtl/odo_dp.sv
rtl/differential_drive_odometry_core.sv
tb/odometry_scoreboard.sv
tb/differential_drive_odometry_core_tb.sv
